// ===== hw/rtl/poly1305_mac_defines.svh =====
// poly1305_mac_defines.svh: assertion macros for the Poly1305 checker.
// No dependencies.
`ifndef POLY1305_MAC_DEFINES_SVH
`define POLY1305_MAC_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define P1305_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("poly1305 check failed");
// next-cycle implication
`define P1305_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("poly1305 check failed");
`endif

// ===== hw/rtl/p1305_pkg.sv =====
// p1305_pkg: widths, limb type and constants for the Poly1305 authenticator.
// No dependencies.
package p1305_pkg;
  localparam int LimbBits = 26;
  localparam int NumLimbs = 5;
  localparam logic [25:0] LimbMask = 26'h3FFFFFF;
  localparam logic [63:0] ClampLow = 64'h0FFFFFFC0FFFFFFF;
  localparam logic [63:0] ClampHigh = 64'h0FFFFFFC0FFFFFFC;
  localparam logic [1:0] RegRLow = 2'd0;
  localparam logic [1:0] RegRHigh = 2'd1;
  localparam logic [1:0] RegSLow = 2'd2;
  localparam logic [1:0] RegSHigh = 2'd3;
  typedef logic [2:0] limb_idx_t;
endpackage

// ===== hw/rtl/p1305_mac_row.sv =====
// p1305_mac_row: one product row of the limb multiply: 5 products of 28x29 bits
// summed. Depends on p1305_pkg.
module p1305_mac_row
  import p1305_pkg::*;
(
  input  logic [4:0][27:0] h,
  input  logic [4:0][28:0] rr,
  output logic [63:0]      d
);
  logic [4:0][56:0] p;
  always_comb begin
    for (int j = 0; j < 5; j++) begin
      p[j] = 57'(h[j]) * 57'(rr[j]);
    end
    d = 64'(p[0]) + 64'(p[1]) + 64'(p[2]) + 64'(p[3]) + 64'(p[4]);
  end
endmodule

// ===== hw/rtl/poly1305_mac.sv =====
// Poly1305 one-time authenticator, five radix-2^26 limbs, one shared row multiplier.
// A len>0 block holds busy through add, five product rows and a carry pass; a last
// block adds two carry passes, select and add s before the tag; len 0 with last runs
// only those. A len-0 block without last is ignored; no new block is taken while busy.
// Tag strobed for one cycle; the receiver cannot stall it.
// Sync active-high reset clears keys, accumulator and control.
module poly1305_mac
  import p1305_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  block_len,
  input  logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        tag_valid,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_CARRY, S_FC1, S_FC2, S_SEL, S_TAG} state_t;
  state_t state;
  logic [63:0] r_key_low, r_key_high, s_key_low, s_key_high;
  logic [4:0][27:0] h;
  logic [4:0][63:0] d;
  logic [2:0] row;
  logic is_last;
  logic [63:0] lo_m, hi_m;
  logic top;
  logic [4:0] len;
  logic [4:0][25:0] rl, c;
  logic [4:0][28:0] rr;
  logic [63:0] row_sum;
  logic [4:0][63:0] cp;

  assign cfg_ready = 1'b1;

  function automatic logic [4:0][25:0] split(input logic [63:0] l, input logic [63:0] u,
                                             input logic t);
    logic [4:0][25:0] v;
    v[0] = l[25:0];
    v[1] = l[51:26];
    v[2] = {u[13:0], l[63:52]};
    v[3] = u[39:14];
    v[4] = {1'b0, t, u[63:40]} ;
    return v;
  endfunction

  function automatic logic [4:0][63:0] carry(input logic [4:0][63:0] x);
    logic [4:0][63:0] y;
    logic [63:0] k;
    k = '0;
    for (int i = 0; i < 5; i++) begin
      y[i] = x[i] + k;
      k = y[i] >> LimbBits;
      y[i] = {38'd0, y[i][25:0]};
    end
    y[0] = y[0] + k * 64'd5;
    k = y[0] >> LimbBits;
    y[0] = {38'd0, y[0][25:0]};
    y[1] = y[1] + k;
    return y;
  endfunction

  always_comb begin
    len = (block_len > 5'd16) ? 5'd16 : block_len;
    lo_m = block_low;
    hi_m = block_high;
    top = 1'b0;
    if (len < 5'd8) begin
      lo_m = (block_low & ((64'd1 << {len[2:0], 3'b000}) - 64'd1))
             | (64'd1 << {len[2:0], 3'b000});
      hi_m = '0;
    end else if (len == 5'd8) begin
      hi_m = 64'd1;
    end else if (len < 5'd16) begin
      hi_m = (block_high & ((64'd1 << {len[2:0], 3'b000}) - 64'd1))
             | (64'd1 << {len[2:0], 3'b000});
    end else begin
      top = 1'b1;
    end
    c = split(lo_m, hi_m, top);
    rl = split(r_key_low & ClampLow, r_key_high & ClampHigh, 1'b0);
    for (int j = 0; j < 5; j++) begin
      if (32'(j) <= 32'(row)) rr[j] = 29'(rl[32'(row) - j]);
      else rr[j] = 29'(rl[32'(row) + 5 - j]) * 29'd5;
    end
    for (int i = 0; i < 5; i++) cp[i] = 64'(h[i]);
    cp = carry((state == S_CARRY) ? d : cp);
  end

  p1305_mac_row u_row (.h(h), .rr(rr), .d(row_sum));

  logic [26:0] gk;
  logic [4:0][25:0] gl;
  logic [25:0] hc0, hc1, hc2, hc3, hc4;
  logic [127:0] hv, sum;
  always_comb begin
    gk = 27'd5;
    for (int i = 0; i < 5; i++) begin
      gk = 27'(h[i]) + 27'(gk[26:26] ? 1 : 0) + ((i == 0) ? 27'd5 : 27'd0);
      gl[i] = gk[25:0];
    end
    hc0 = h[0][25:0]; hc1 = h[1][25:0]; hc2 = h[2][25:0];
    hc3 = h[3][25:0]; hc4 = h[4][25:0];
    hv = {hc4[23:0], hc3, hc2, hc1, hc0};
    sum = hv + {s_key_high, s_key_low};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
      tag_valid <= 1'b0;
      h <= '0;
      r_key_low <= '0;
      r_key_high <= '0;
      s_key_low <= '0;
      s_key_high <= '0;
      row <= '0;
      is_last <= 1'b0;
    end else begin
      tag_valid <= (state == S_TAG);
      if (cfg_valid) begin
        case (cfg_index)
          RegRLow:  r_key_low <= cfg_data;
          RegRHigh: r_key_high <= cfg_data;
          RegSLow:  s_key_low <= cfg_data;
          RegSHigh: s_key_high <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            busy <= (len != 5'd0) || last;
            is_last <= last;
            row <= '0;
            if (len != 5'd0) begin
              for (int i = 0; i < 5; i++) h[i] <= h[i] + 28'(c[i]);
              state <= S_MUL;
            end else if (last) begin
              state <= S_FC1;
            end
          end
        end
        S_MUL: begin
          d[row] <= row_sum;
          if (row == 3'd4) begin
            state <= S_CARRY;
            row <= '0;
          end else begin
            row <= row + 3'd1;
          end
        end
        S_CARRY: begin
          for (int i = 0; i < 5; i++) h[i] <= cp[i][27:0];
          if (is_last) state <= S_FC1;
          else begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        S_FC1: begin
          for (int i = 0; i < 5; i++) h[i] <= cp[i][27:0];
          state <= S_FC2;
        end
        S_FC2: begin
          for (int i = 0; i < 5; i++) h[i] <= cp[i][27:0];
          state <= S_SEL;
        end
        S_SEL: begin
          if (gk[26]) for (int i = 0; i < 5; i++) h[i] <= 28'(gl[i]);
          state <= S_TAG;
        end
        S_TAG: begin
          tag_low <= sum[63:0];
          tag_high <= sum[127:64];
          h <= '0;
          busy <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hw/rtl/poly1305_mac_checker.sv =====
// poly1305_mac_checker: port-level checks on the Poly1305 authenticator, bound in.
// Depends on poly1305_mac_defines.svh.
`include "poly1305_mac_defines.svh"
module poly1305_mac_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic [4:0] block_len,
  input logic tag_valid
);
  `P1305_ASSERT_NEXT(a_tag_single, tag_valid, !tag_valid)
  `P1305_ASSERT(a_tag_idle, tag_valid, !busy)
  `P1305_ASSERT_NEXT(a_nolast_notag, start && !busy && !last, !tag_valid)
  `P1305_ASSERT_NEXT(a_busy_after, start && !busy && (last || block_len != 5'd0), busy)
endmodule

bind poly1305_mac poly1305_mac_checker u_chk (.clk(clk), .rst(rst), .start(start),
  .busy(busy), .last(last), .block_len(block_len), .tag_valid(tag_valid));
